// ===== src/assert_macros.svh =====
// assertion macros used by the top-level rtl file
// each macro expects clk and arst_n to be in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/cpms_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the controller port block
// no dependencies
package cpms_pkg;

	localparam int PLAYERS = 6;
	localparam int PLAYER_W = 3;
	localparam int BTN_W = 3;
	localparam int PAD_W = 8;
	localparam int REM_W = 5;
	localparam int SIG_W = 8;

	localparam logic [REM_W-1:0] REM_LOAD = 5'd16;
	localparam logic [REM_W-1:0] REM_FAR = 5'd8;
	localparam logic [SIG_W-1:0] SIG_NEAR = 8'h08;
	localparam logic [SIG_W-1:0] SIG_FAR = 8'h04;
	localparam logic [PLAYER_W-1:0] PAIR_STEP = 3'd2;

	typedef enum logic [1:0] {
		MODE_BUTTON = 2'd0,
		MODE_STROBE = 2'd1,
		MODE_READ = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		AM_NONE = 2'd0,
		AM_TAP = 2'd1,
		AM_EXP2 = 2'd2,
		AM_EXP4 = 2'd3
	} adapter_mode_t;

	typedef enum logic [1:0] {
		REG_ADAPTER_MODE = 2'd0,
		REG_PORT0_PRESENT = 2'd1,
		REG_PORT1_PRESENT = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic edit;
		logic [BTN_W-1:0] button;
		logic pressed;
		logic latch;
		logic shift;
		logic strobe;
	} pad_ctrl_t;

	typedef struct packed {
		logic clear;
		logic reload;
		logic read;
		logic strobe;
		logic [SIG_W-1:0] reload_sig;
	} tap_ctrl_t;

	typedef struct packed {
		logic active;
		logic far;
		logic sig_bit;
	} tap_status_t;

endpackage

// ===== src/cpms_pad.sv =====
`timescale 1ns / 1ps
// one gamepad: live button register and parallel-load shift register
// depends on cpms_pkg
module cpms_pad (
	input logic clk,
	input logic arst_n,
	input cpms_pkg::pad_ctrl_t ctrl,
	output logic data_bit
);

	logic [cpms_pkg::PAD_W-1:0] buttons_q;
	logic [cpms_pkg::PAD_W-1:0] shift_q;

	assign data_bit = ctrl.strobe ? buttons_q[0] : shift_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buttons_q <= '0;
			shift_q <= '0;
		end else begin
			if (ctrl.edit) begin
				buttons_q[ctrl.button] <= ctrl.pressed;
			end
			if (ctrl.latch) begin
				shift_q <= buttons_q;
			end else if (ctrl.shift) begin
				if (ctrl.strobe) begin
					shift_q <= buttons_q;
				end else begin
					shift_q <= {1'b1, shift_q[cpms_pkg::PAD_W-1:1]};
				end
			end
		end
	end

endmodule

// ===== src/cpms_tap.sv =====
`timescale 1ns / 1ps
// one adapter channel: bit counter and signature shift register
// depends on cpms_pkg
module cpms_tap (
	input logic clk,
	input logic arst_n,
	input cpms_pkg::tap_ctrl_t ctrl,
	output cpms_pkg::tap_status_t status
);

	logic [cpms_pkg::REM_W-1:0] rem_q;
	logic [cpms_pkg::REM_W-1:0] rem_eff;
	logic [cpms_pkg::REM_W-1:0] rem_dec;
	logic [cpms_pkg::SIG_W-1:0] sig_q;
	logic [cpms_pkg::SIG_W-1:0] sig_eff;

	// strobe high reloads before the read
	always_comb begin
		rem_eff = ctrl.strobe ? cpms_pkg::REM_LOAD : rem_q;
		sig_eff = ctrl.strobe ? ctrl.reload_sig : sig_q;
		rem_dec = rem_eff - cpms_pkg::REM_W'(1);
		status.active = (rem_eff != '0);
		status.far = (rem_dec < cpms_pkg::REM_FAR);
		status.sig_bit = sig_eff[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			sig_q <= '0;
		end else if (ctrl.clear) begin
			rem_q <= '0;
			sig_q <= '0;
		end else if (ctrl.reload) begin
			rem_q <= cpms_pkg::REM_LOAD;
			sig_q <= ctrl.reload_sig;
		end else if (ctrl.read) begin
			if (status.active) begin
				rem_q <= rem_dec;
				sig_q <= sig_eff;
			end else begin
				rem_q <= rem_eff;
				sig_q <= {1'b1, sig_eff[cpms_pkg::SIG_W-1:1]};
			end
		end
	end

endmodule

// ===== src/controller_port_multitap_shift_top.sv =====
`timescale 1ns / 1ps
// Two controller ports with eight-button pads and a multi-player adapter.
// Takes one item per clock cycle when not stalled: an item goes into the input
// register, its whole effect on the pad and adapter state is applied when it
// leaves that register, and a port read then shows its result on the output
// stream from the output register. Button changes and strobe writes give no
// result. The output register holds a waiting result while one more item sits
// in the input register; the input stalls only when both are full and the
// output is held back. Configuration writes are meant for idle periods; an
// adapter mode write clears both adapter channels.
// Depends on cpms_pkg, cpms_pad, cpms_tap and assert_macros.svh.
`include "assert_macros.svh"

module controller_port_multitap_shift_top (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	// player [2:0], button [5:3], pressed [6], strobe_level [7], port [8]
	input logic [15:0] s_axis_tdata,
	// mode [1:0]
	input logic [1:0] s_axis_tuser,
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	// read_data [1:0]
	output logic [7:0] m_axis_tdata,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [3:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	localparam int PL = cpms_pkg::PLAYERS;
	localparam int PW = cpms_pkg::PLAYER_W;

	// configuration
	cpms_pkg::adapter_mode_t am_q;
	logic p0_present_q;
	logic p1_present_q;
	logic cfg_wr;
	cpms_pkg::reg_idx_t cfg_idx;

	// input stage
	logic valid_s1;
	cpms_pkg::mode_t mode_s1;
	logic [PW-1:0] player_s1;
	logic [cpms_pkg::BTN_W-1:0] button_s1;
	logic pressed_s1;
	logic level_s1;
	logic port_s1;

	// state and result
	logic strobe_q;
	logic out_valid_q;
	logic [1:0] out_data_q;

	logic fire_s1;
	logic rd;
	logic tap_path;
	logic strobe_fall;
	logic present;
	logic tap_bit;
	logic d0;
	logic d1;
	logic [PW-1:0] tap_idx;
	logic [PW-1:0] port_idx;
	logic [PL-1:0] sel_tap;
	logic [PL-1:0] sel_d0;
	logic [PL-1:0] sel_d1;
	logic [PL-1:0] pad_bit;
	cpms_pkg::tap_status_t ts;
	cpms_pkg::tap_status_t tap_st [2];
	cpms_pkg::tap_ctrl_t tap_ctrl [2];
	cpms_pkg::pad_ctrl_t pad_ctrl [PL];

	// apb
	assign pready = 1'b1;
	assign cfg_idx = cpms_pkg::reg_idx_t'(paddr[3:2]);
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		case (cfg_idx)
			cpms_pkg::REG_ADAPTER_MODE: prdata = {30'd0, am_q};
			cpms_pkg::REG_PORT0_PRESENT: prdata = {31'd0, p0_present_q};
			cpms_pkg::REG_PORT1_PRESENT: prdata = {31'd0, p1_present_q};
			default: prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			am_q <= cpms_pkg::AM_NONE;
			p0_present_q <= 1'b1;
			p1_present_q <= 1'b1;
		end else if (cfg_wr) begin
			case (cfg_idx)
				cpms_pkg::REG_ADAPTER_MODE: am_q <= cpms_pkg::adapter_mode_t'(pwdata[1:0]);
				cpms_pkg::REG_PORT0_PRESENT: p0_present_q <= pwdata[0];
				cpms_pkg::REG_PORT1_PRESENT: p1_present_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	// handshake
	assign fire_s1 = valid_s1 && (mode_s1 != cpms_pkg::MODE_READ || !out_valid_q
		|| m_axis_tready);
	assign s_axis_tready = !valid_s1 || fire_s1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {6'd0, out_data_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			mode_s1 <= cpms_pkg::mode_t'(s_axis_tuser);
			player_s1 <= s_axis_tdata[2:0];
			button_s1 <= s_axis_tdata[5:3];
			pressed_s1 <= s_axis_tdata[6];
			level_s1 <= s_axis_tdata[7];
			port_s1 <= s_axis_tdata[8];
		end
	end

	// read decode
	always_comb begin
		rd = valid_s1 && mode_s1 == cpms_pkg::MODE_READ;
		tap_path = rd && (am_q == cpms_pkg::AM_TAP || am_q == cpms_pkg::AM_EXP4);
		strobe_fall = valid_s1 && mode_s1 == cpms_pkg::MODE_STROBE && strobe_q && !level_s1;
		ts = tap_st[port_s1];
		port_idx = {{(PW-1){1'b0}}, port_s1};
		tap_idx = port_idx
			+ ((am_q == cpms_pkg::AM_EXP4) ? cpms_pkg::PAIR_STEP : '0)
			+ (ts.far ? cpms_pkg::PAIR_STEP : '0);
		present = port_s1 ? p1_present_q : p0_present_q;
		for (int i = 0; i < PL; i++) begin
			sel_tap[i] = tap_path && ts.active && tap_idx == PW'(i);
			sel_d0[i] = rd && am_q != cpms_pkg::AM_TAP && present && port_idx == PW'(i);
			sel_d1[i] = rd && am_q == cpms_pkg::AM_EXP2
				&& (port_idx + cpms_pkg::PAIR_STEP) == PW'(i);
		end
		tap_bit = ts.active ? |(sel_tap & pad_bit) : ts.sig_bit;
		d0 = (am_q == cpms_pkg::AM_TAP) ? tap_bit : |(sel_d0 & pad_bit);
		case (am_q)
			cpms_pkg::AM_EXP2: d1 = |(sel_d1 & pad_bit);
			cpms_pkg::AM_EXP4: d1 = tap_bit;
			default: d1 = 1'b0;
		endcase
	end

	// pad lanes
	for (genvar g = 0; g < PL; g++) begin : g_pad
		always_comb begin
			pad_ctrl[g].edit = fire_s1 && mode_s1 == cpms_pkg::MODE_BUTTON
				&& player_s1 == PW'(g);
			pad_ctrl[g].button = button_s1;
			pad_ctrl[g].pressed = pressed_s1;
			pad_ctrl[g].latch = fire_s1 && strobe_fall;
			pad_ctrl[g].shift = fire_s1 && (sel_tap[g] || sel_d0[g] || sel_d1[g]);
			pad_ctrl[g].strobe = strobe_q;
		end
		cpms_pad u_pad (
			.clk(clk),
			.arst_n(arst_n),
			.ctrl(pad_ctrl[g]),
			.data_bit(pad_bit[g])
		);
	end

	// adapter channels
	for (genvar g = 0; g < 2; g++) begin : g_tap
		always_comb begin
			tap_ctrl[g].clear = cfg_wr && cfg_idx == cpms_pkg::REG_ADAPTER_MODE;
			tap_ctrl[g].reload = fire_s1 && strobe_fall;
			tap_ctrl[g].read = fire_s1 && tap_path && port_s1 == 1'(g);
			tap_ctrl[g].strobe = strobe_q;
			tap_ctrl[g].reload_sig = ((am_q == cpms_pkg::AM_TAP) == (g == 0))
				? cpms_pkg::SIG_NEAR : cpms_pkg::SIG_FAR;
		end
		cpms_tap u_tap (
			.clk(clk),
			.arst_n(arst_n),
			.ctrl(tap_ctrl[g]),
			.status(tap_st[g])
		);
	end

	// strobe and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire_s1 && mode_s1 == cpms_pkg::MODE_STROBE) begin
				strobe_q <= level_s1;
			end
			if (fire_s1 && rd) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && rd) begin
			out_data_q <= {d1, d0};
		end
	end

	`ASSERT_NEXT(a_read_gives_item, fire_s1 && rd, out_valid_q, "read item without result")
	`ASSERT_NOW(a_stall_only_full, !s_axis_tready, valid_s1 && out_valid_q, "stall while not full")
	`ASSERT_NOW(a_two_pads_max, 1'b1, $countones(sel_tap | sel_d0 | sel_d1) <= 2, "too many pads shifted")
	`ASSERT_NEXT(a_fall_clears_strobe, fire_s1 && strobe_fall, !strobe_q, "strobe not cleared on fall")
	`ASSERT_NOW(a_tap_no_plain, am_q == cpms_pkg::AM_TAP, (sel_d0 | sel_d1) == '0, "plain pad read in tap mode")

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// self-checking testbench for controller_port_multitap_shift_top: stream items in,
// read results checked against a scoreboard that models the pads and the adapter
// depends on cpms_pkg and the rtl under src
module tb_top;

	localparam logic [1:0] MODE_SPARE = 2'd3;
	localparam int QUIET_LIMIT = 5000;
	localparam int SETTLE_CYCLES = 4;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 90;

	typedef struct packed {
		logic [6:0] fill;
		logic port;
		logic level;
		logic pressed;
		logic [cpms_pkg::BTN_W-1:0] button;
		logic [cpms_pkg::PLAYER_W-1:0] player;
	} port_item_t;

	class pad_port_scoreboard;
		cpms_pkg::adapter_mode_t adapter;
		logic present [2];
		logic [cpms_pkg::PAD_W-1:0] live [cpms_pkg::PLAYERS];
		logic [cpms_pkg::PAD_W-1:0] shifter [cpms_pkg::PLAYERS];
		logic strobe;
		logic [cpms_pkg::REM_W-1:0] remaining [2];
		logic [cpms_pkg::SIG_W-1:0] signature [2];
		logic [1:0] pending_reads [$];
		int faults;

		function new();
			adapter = cpms_pkg::AM_NONE;
			present = '{1'b1, 1'b1};
			foreach (live[i]) begin
				live[i] = '0;
				shifter[i] = '0;
			end
			strobe = 1'b0;
			remaining = '{default: '0};
			signature = '{default: '0};
			faults = 0;
		endfunction

		function void reload_tap();
			remaining[0] = cpms_pkg::REM_LOAD;
			remaining[1] = cpms_pkg::REM_LOAD;
			signature[0] = (adapter == cpms_pkg::AM_TAP) ? cpms_pkg::SIG_NEAR
				: cpms_pkg::SIG_FAR;
			signature[1] = (adapter == cpms_pkg::AM_TAP) ? cpms_pkg::SIG_FAR
				: cpms_pkg::SIG_NEAR;
		endfunction

		function logic pad_bit(int unsigned idx);
			logic b;
			if (idx >= cpms_pkg::PLAYERS)
				return 1'b0;
			if (strobe)
				shifter[idx] = live[idx];
			b = shifter[idx][0];
			if (!strobe)
				shifter[idx] = {1'b1, shifter[idx][cpms_pkg::PAD_W-1:1]};
			return b;
		endfunction

		function logic tap_bit(int unsigned p);
			int unsigned idx;
			logic b;
			if (strobe)
				reload_tap();
			if (remaining[p] != '0) begin
				idx = p;
				if (adapter == cpms_pkg::AM_EXP4)
					idx += cpms_pkg::PAIR_STEP;
				remaining[p] = remaining[p] - 1'b1;
				if (remaining[p] < cpms_pkg::REM_FAR)
					idx += cpms_pkg::PAIR_STEP;
				return pad_bit(idx);
			end
			b = signature[p][0];
			signature[p] = {1'b1, signature[p][cpms_pkg::SIG_W-1:1]};
			return b;
		endfunction

		function void set_reg(cpms_pkg::reg_idx_t idx, logic [31:0] value);
			case (idx)
				cpms_pkg::REG_ADAPTER_MODE: begin
					adapter = cpms_pkg::adapter_mode_t'(value[1:0]);
					remaining = '{default: '0};
					signature = '{default: '0};
				end
				cpms_pkg::REG_PORT0_PRESENT: present[0] = value[0];
				cpms_pkg::REG_PORT1_PRESENT: present[1] = value[0];
				default: ;
			endcase
		endfunction

		function logic [31:0] reg_value(cpms_pkg::reg_idx_t idx);
			case (idx)
				cpms_pkg::REG_ADAPTER_MODE: return {30'd0, adapter};
				cpms_pkg::REG_PORT0_PRESENT: return {31'd0, present[0]};
				cpms_pkg::REG_PORT1_PRESENT: return {31'd0, present[1]};
				default: return '0;
			endcase
		endfunction

		function void take_item(logic [1:0] mode, port_item_t it);
			logic d0;
			logic d1;
			d0 = 1'b0;
			d1 = 1'b0;
			case (mode)
				cpms_pkg::MODE_BUTTON: begin
					if (it.player < cpms_pkg::PLAYERS)
						live[it.player][it.button] = it.pressed;
				end
				cpms_pkg::MODE_STROBE: begin
					if (strobe && !it.level) begin
						foreach (shifter[i])
							shifter[i] = live[i];
						reload_tap();
					end
					strobe = it.level;
				end
				cpms_pkg::MODE_READ: begin
					if (adapter == cpms_pkg::AM_TAP) begin
						d0 = tap_bit(it.port);
					end else begin
						if (present[it.port])
							d0 = pad_bit(it.port);
						if (adapter == cpms_pkg::AM_EXP2)
							d1 = pad_bit(cpms_pkg::PAIR_STEP + it.port);
						else if (adapter == cpms_pkg::AM_EXP4)
							d1 = tap_bit(it.port);
					end
					pending_reads.push_back({d1, d0});
				end
				default: ;
			endcase
		endfunction

		function void check_read(logic [7:0] got);
			logic [1:0] want;
			if (pending_reads.size() == 0) begin
				$display("%0t: read_data expected none actual %h", $time, got);
				faults++;
				return;
			end
			want = pending_reads.pop_front();
			if (got !== {6'd0, want}) begin
				$display("%0t: read_data expected %h actual %h", $time, want, got);
				faults++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [15:0] s_axis_tdata = '0;
	logic [1:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	logic calm = 1'b0;
	int items_sent = 0;
	int quiet = 0;
	pad_port_scoreboard board = new();

	controller_port_multitap_shift_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic bit idle_now();
		return !calm && ($urandom_range(99) < 18);
	endfunction

	function automatic port_item_t make_item(int player, int button, int pressed, int level,
		int port);
		port_item_t it;
		it = '0;
		it.player = cpms_pkg::PLAYER_W'(player);
		it.button = cpms_pkg::BTN_W'(button);
		it.pressed = pressed[0];
		it.level = level[0];
		it.port = port[0];
		return it;
	endfunction

	function automatic port_item_t rand_item();
		return make_item($urandom_range(7), $urandom_range(7), $urandom_range(1),
			$urandom_range(1), $urandom_range(1));
	endfunction

	task automatic send_item(input logic [1:0] mode, input port_item_t it);
		while (idle_now()) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= it;
		s_axis_tuser <= mode;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		board.take_item(mode, it);
		if (mode != MODE_SPARE)
			items_sent++;
	endtask

	// stop sending until every pending read has come back, then let the pipe empty
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (board.pending_reads.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cpms_pkg::reg_idx_t idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		board.set_reg(idx, value);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== board.reg_value(idx)) begin
			$display("%0t: register %0d expected %h actual %h", $time, idx,
				board.reg_value(idx), prdata);
			board.faults++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic random_phase(input int quota);
		port_item_t it;
		logic fav;
		int start;
		bit paused;
		start = items_sent;
		paused = 1'b0;
		while (items_sent - start < quota) begin
			if (!paused && items_sent - start >= quota / 2) begin
				settle();
				paused = 1'b1;
			end
			if ($urandom_range(9) < 8) begin
				// button edits, latch, then a burst of reads mostly on one port
				repeat ($urandom_range(4)) begin
					it = rand_item();
					it.player = ($urandom_range(9) == 0)
						? cpms_pkg::PLAYER_W'($urandom_range(7, 6))
						: cpms_pkg::PLAYER_W'($urandom_range(5));
					send_item(cpms_pkg::MODE_BUTTON, it);
				end
				it = rand_item();
				it.level = 1'b1;
				send_item(cpms_pkg::MODE_STROBE, it);
				repeat ($urandom_range(2)) send_item(cpms_pkg::MODE_READ, rand_item());
				it = rand_item();
				it.level = 1'b0;
				send_item(cpms_pkg::MODE_STROBE, it);
				fav = 1'($urandom_range(1));
				repeat ($urandom_range(1, 48)) begin
					it = rand_item();
					it.port = ($urandom_range(4) == 0) ? !fav : fav;
					send_item(cpms_pkg::MODE_READ, it);
				end
			end else begin
				repeat ($urandom_range(1, 6)) send_item(2'($urandom_range(3)), rand_item());
			end
		end
	endtask

	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready)
			board.check_read(m_axis_tdata);
		m_axis_tready <= calm || ($urandom_range(99) >= 18);
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		cpms_pkg::adapter_mode_t plan_mode [PHASES];
		logic plan_p0 [PHASES];
		logic plan_p1 [PHASES];
		plan_mode = '{cpms_pkg::AM_TAP, cpms_pkg::AM_EXP2, cpms_pkg::AM_EXP4,
			cpms_pkg::AM_NONE, cpms_pkg::AM_TAP, cpms_pkg::AM_EXP4, cpms_pkg::AM_EXP2,
			cpms_pkg::AM_NONE};
		plan_p0 = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1};
		plan_p1 = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(cpms_pkg::MODE_BUTTON, make_item(0, 0, 1, 0, 0));
		send_item(cpms_pkg::MODE_BUTTON, make_item(0, 7, 1, 0, 0));
		send_item(cpms_pkg::MODE_BUTTON, make_item(1, 3, 1, 0, 0));
		send_item(cpms_pkg::MODE_BUTTON, make_item(1, 3, 0, 0, 0));
		send_item(cpms_pkg::MODE_BUTTON, make_item(1, 4, 1, 0, 0));
		send_item(cpms_pkg::MODE_BUTTON, make_item(5, 7, 1, 0, 0));
		// players past the last pad are ignored
		send_item(cpms_pkg::MODE_BUTTON, make_item(6, 0, 1, 0, 0));
		send_item(cpms_pkg::MODE_BUTTON, make_item(7, 7, 1, 1, 1));
		send_item(cpms_pkg::MODE_READ, make_item(0, 0, 0, 0, 0));
		send_item(cpms_pkg::MODE_STROBE, make_item(0, 0, 0, 1, 0));
		send_item(cpms_pkg::MODE_READ, make_item(7, 7, 1, 1, 0));
		send_item(cpms_pkg::MODE_READ, make_item(0, 0, 0, 0, 1));
		send_item(cpms_pkg::MODE_STROBE, make_item(0, 0, 0, 1, 0));
		send_item(cpms_pkg::MODE_STROBE, make_item(7, 7, 1, 0, 1));
		repeat (9) send_item(cpms_pkg::MODE_READ, make_item(0, 0, 0, 0, 0));
		send_item(cpms_pkg::MODE_READ, make_item(0, 0, 0, 0, 1));
		send_item(MODE_SPARE, make_item(7, 7, 1, 1, 1));
		send_item(cpms_pkg::MODE_STROBE, make_item(0, 0, 0, 0, 0));

		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			write_reg(cpms_pkg::REG_ADAPTER_MODE, {30'd0, plan_mode[ph]});
			write_reg(cpms_pkg::REG_PORT0_PRESENT, {31'd0, plan_p0[ph]});
			write_reg(cpms_pkg::REG_PORT1_PRESENT, {31'd0, plan_p1[ph]});
			calm = (ph == 2);
			random_phase(PHASE_ITEMS);
		end
		calm = 1'b0;

		settle();
		if (board.faults == 0 && board.pending_reads.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
